@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the permute address generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CHECK_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CHECK_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tapa_pkg.sv @@
// Types and constants of the tensor axis permute address generator.
package tapa_pkg;

	localparam int MAX_RANK     = 6;
	localparam int MAX_EXTENT   = 1024;
	localparam int INDEX_BITS   = 20;

	localparam int NUM_EXT_REGS = 6;
	localparam int AXIS_W       = 3;
	localparam int RANK_REG_W   = 3;
	localparam int EXT_REG_W    = 11;
	localparam int ORDER_REG_W  = 18;
	localparam int VALUE_W      = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 18;

	localparam int DIGIT_W  = $clog2(MAX_EXTENT);
	localparam int EXTU_W   = DIGIT_W + 1;
	localparam int RANK_W   = $clog2(MAX_RANK + 1);
	localparam int STEP_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int COUNT_W  = INDEX_BITS + EXTU_W;

	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANK     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXT0     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_LAST = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 3'd7;

	typedef struct packed {
		logic                                busy;
		logic                                restart;
		logic                                bad;
		logic [MAX_RANK-1:0][EXTU_W-1:0]     used_ext;
		logic [MAX_RANK-1:0][INDEX_BITS-1:0] stride;
	} cfg_t;

	typedef struct packed {
		logic [VALUE_W-1:0]               value;
		logic [MAX_RANK-1:0][DIGIT_W-1:0] digits;
		logic                             last;
	} item_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] dest;
		logic [VALUE_W-1:0]    value;
		logic                  last;
		logic                  err;
	} res_t;

endpackage

@@ rtl/core/tapa_cfg.sv @@
// Configuration registers and the per-axis stride and error sequencer.
`include "assert_macros.svh"

module tapa_cfg import tapa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(1) << INDEX_BITS;

	logic [RANK_REG_W-1:0]                   rank_q;
	logic [NUM_EXT_REGS-1:0][EXT_REG_W-1:0]  ext_q;
	logic [ORDER_REG_W-1:0]                  order_q;

	logic                                busy_q;
	logic [STEP_W-1:0]                   step_q;
	logic [COUNT_W-1:0]                  count_q;
	logic [COUNT_W-1:0]                  span_q;
	logic [MAX_RANK-1:0]                 seen_q;
	logic                                bad_q;
	logic [MAX_RANK-1:0][INDEX_BITS-1:0] stride_q;

	logic [RANK_W-1:0]               used_rank;
	logic [MAX_RANK-1:0][EXTU_W-1:0] used_ext;
	logic [MAX_RANK-1:0][AXIS_W-1:0] order_f;

	always_comb begin
		if (rank_q == '0) begin
			used_rank = RANK_W'(1);
		end else if (32'(rank_q) > MAX_RANK) begin
			used_rank = RANK_W'(MAX_RANK);
		end else begin
			used_rank = RANK_W'(rank_q);
		end
	end

	for (genvar j = 0; j < MAX_RANK; j++) begin : g_axis
		logic [EXT_REG_W-1:0] raw;
		logic [EXTU_W-1:0]    clamped;
		if (j < NUM_EXT_REGS) begin : g_reg
			assign raw = ext_q[j];
			assign order_f[j] = order_q[AXIS_W*j +: AXIS_W];
		end else begin : g_none
			assign raw = EXT_REG_W'(1);
			assign order_f[j] = '0;
		end
		always_comb begin
			if (raw == '0) begin
				clamped = EXTU_W'(1);
			end else if (32'(raw) > MAX_EXTENT) begin
				clamped = EXTU_W'(MAX_EXTENT);
			end else begin
				clamped = EXTU_W'(raw);
			end
		end
		assign used_ext[j] = (j < 32'(used_rank)) ? clamped : EXTU_W'(1);
	end

	// one output position per cycle: permutation check, element count, stride
	logic                in_use;
	logic [AXIS_W-1:0]   axis_sel;
	logic [STEP_W-1:0]   axis_idx;
	logic                axis_ok;
	logic [COUNT_W-1:0]  count_n;
	logic [COUNT_W-1:0]  span_n;
	logic                last_step;

	always_comb begin
		in_use    = 32'(step_q) < 32'(used_rank);
		axis_sel  = order_f[step_q];
		axis_idx  = STEP_W'(axis_sel);
		axis_ok   = (32'(axis_sel) < 32'(used_rank)) && !seen_q[axis_idx];
		count_n   = (count_q <= LIMIT) ? COUNT_W'(count_q * used_ext[step_q]) : count_q;
		span_n    = (span_q <= LIMIT) ? COUNT_W'(span_q * used_ext[axis_idx]) : span_q;
		last_step = step_q == STEP_W'(MAX_RANK - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q   <= RANK_REG_W'(1);
			for (int i = 0; i < NUM_EXT_REGS; i++) begin
				ext_q[i] <= EXT_REG_W'(1);
			end
			for (int i = 0; i < NUM_EXT_REGS; i++) begin
				order_q[AXIS_W*i +: AXIS_W] <= AXIS_W'(i);
			end
			busy_q   <= 1'b0;
			step_q   <= '0;
			count_q  <= COUNT_W'(1);
			span_q   <= COUNT_W'(1);
			seen_q   <= '0;
			bad_q    <= 1'b0;
			// identity layout of rank one: only position zero has a stride
			stride_q <= {{(MAX_RANK-1){INDEX_BITS'(0)}}, INDEX_BITS'(1)};
		end else if (cfg_write) begin
			unique case (cfg_index) inside
				REG_RANK:                 rank_q  <= cfg_data[RANK_REG_W-1:0];
				[REG_EXT0:REG_EXT_LAST]:  ext_q[cfg_index - REG_EXT0] <= cfg_data[EXT_REG_W-1:0];
				REG_ORDER:                order_q <= cfg_data[ORDER_REG_W-1:0];
				default: ;
			endcase
			busy_q   <= 1'b1;
			step_q   <= '0;
			count_q  <= COUNT_W'(1);
			span_q   <= COUNT_W'(1);
			seen_q   <= '0;
			bad_q    <= 1'b0;
			stride_q <= '0;
		end else if (busy_q) begin
			if (in_use) begin
				count_q <= count_n;
				if (axis_ok) begin
					seen_q[axis_idx]   <= 1'b1;
					stride_q[axis_idx] <= span_q[INDEX_BITS-1:0];
					span_q             <= span_n;
				end
			end
			if ((in_use && !axis_ok) ||
					(last_step && ((in_use ? count_n : count_q) > LIMIT))) begin
				bad_q <= 1'b1;
			end
			if (last_step) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	assign cfg.busy     = busy_q;
	assign cfg.restart  = cfg_write;
	assign cfg.bad      = bad_q;
	assign cfg.used_ext = used_ext;
	assign cfg.stride   = stride_q;

	`CHECK_IMPLIES(a_busy_ends_on_last, $fell(busy_q), $past(last_step), "sequencer left busy early")
	`CHECK_IMPLIES(a_idle_step_zero, !busy_q, step_q == '0, "step counter moved while idle")
	`CHECK_NEXT(a_write_starts, cfg_write, busy_q, "register write did not start sequencer")

endmodule

@@ rtl/core/tapa_front.sv @@
// Front end: accepts elements, runs the source digit counter, queues work items.
module tapa_front import tapa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               push,
	input  logic [VALUE_W-1:0] element_bits,
	input  logic               first_element,
	output logic               full,
	input  logic               mid_pop,
	output logic               mid_valid,
	output item_t              mid_item
);

	logic [MAX_RANK-1:0][DIGIT_W-1:0] digits_q;
	logic [MAX_RANK-1:0][DIGIT_W-1:0] cur;
	logic [MAX_RANK-1:0][DIGIT_W-1:0] nxt;
	logic                             last;
	logic                             carry;
	logic                             hit;
	logic                             accept;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_comb begin
		cur   = first_element ? '0 : digits_q;
		last  = 1'b1;
		carry = 1'b1;
		nxt   = cur;
		hit   = 1'b0;
		// ripple increment; axes past the rank have extent one and stay zero
		for (int j = 0; j < MAX_RANK; j++) begin
			hit = (EXTU_W'(cur[j]) + EXTU_W'(1)) < cfg.used_ext[j];
			if (hit) begin
				last = 1'b0;
			end
			if (carry) begin
				if (hit) begin
					nxt[j] = cur[j] + DIGIT_W'(1);
					carry  = 1'b0;
				end else begin
					nxt[j] = '0;
				end
			end
		end
	end

	assign full      = cfg.busy || (cnt_q == QCNT_W'(QDEPTH));
	assign accept    = push && !full;
	assign mid_valid = cnt_q != '0;
	assign mid_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg.restart) begin
				digits_q <= '0;
			end else if (accept) begin
				digits_q <= nxt;
			end
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (mid_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(accept) - QCNT_W'(mid_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_ptr_q] <= '{value: element_bits, digits: cur, last: last};
		end
	end

endmodule

@@ rtl/core/tapa_back.sv @@
// Back end: digit times stride products, index sum and the result queue.
`include "assert_macros.svh"

module tapa_back import tapa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  mid_valid,
	input  item_t                 mid_item,
	output logic                  mid_pop,
	input  logic                  pop,
	output logic                  empty,
	output logic [INDEX_BITS-1:0] dest_index,
	output logic [VALUE_W-1:0]    value_out,
	output logic                  last_element,
	output logic                  config_error
);

	localparam int OCC_W = QCNT_W + 1;

	logic                                v_s1;
	logic [MAX_RANK-1:0][INDEX_BITS-1:0] prod_s1;
	logic [VALUE_W-1:0]                  value_s1;
	logic                                last_s1;
	logic                                err_s1;

	logic                  v_s2;
	res_t                  res_s2;

	logic [INDEX_BITS-1:0] sum;
	logic [OCC_W-1:0]      occupancy;
	logic                  pop_ok;

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] out_cnt_q;

	// issue only with room reserved for everything in flight
	assign occupancy = OCC_W'(out_cnt_q) + OCC_W'(v_s1) + OCC_W'(v_s2);
	assign mid_pop   = mid_valid && (occupancy < OCC_W'(QDEPTH));
	assign empty     = out_cnt_q == '0;
	assign pop_ok    = pop && !empty;

	always_comb begin
		sum = '0;
		for (int i = 0; i < MAX_RANK; i++) begin
			sum = sum + prod_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			out_cnt_q <= out_cnt_q + QCNT_W'(v_s2) - QCNT_W'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RANK; i++) begin
			prod_s1[i] <= INDEX_BITS'(INDEX_BITS'(mid_item.digits[i]) * cfg.stride[i]);
		end
		value_s1 <= mid_item.value;
		last_s1  <= mid_item.last;
		err_s1   <= cfg.bad;

		res_s2.dest  <= err_s1 ? '0 : sum;
		res_s2.value <= value_s1;
		res_s2.last  <= last_s1;
		res_s2.err   <= err_s1;

		if (v_s2) begin
			mem_q[wr_ptr_q] <= res_s2;
		end
	end

	assign dest_index   = mem_q[rd_ptr_q].dest;
	assign value_out    = mem_q[rd_ptr_q].value;
	assign last_element = mem_q[rd_ptr_q].last;
	assign config_error = mem_q[rd_ptr_q].err;

	`CHECK_ALWAYS(a_credit, occupancy <= OCC_W'(QDEPTH), "result queue over-committed")
	`CHECK_IMPLIES(a_no_overflow, v_s2, out_cnt_q < QCNT_W'(QDEPTH), "write into full result queue")
	`CHECK_NEXT(a_pop_drains, pop_ok && !v_s2, out_cnt_q == $past(out_cnt_q) - QCNT_W'(1), "pop did not drain")

endmodule

@@ rtl/core/tensor_axis_permute_address.sv @@
// Top level of the tensor axis permute address generator.
// An element passes the work queue, the product and sum registers and the result queue.
// Throughput: one element per clock unless full; result and work queues decouple ends.
// A register write clears the source counter and holds full high while the sequencer
// derives strides and the error flag, one output axis per cycle.
// Reset is asynchronous, active low: rank 1, extents 1, identity order, queues empty.
module tensor_axis_permute_address import tapa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [VALUE_W-1:0]    element_bits,
	input  logic                  first_element,
	output logic                  empty,
	input  logic                  pop,
	output logic [INDEX_BITS-1:0] dest_index,
	output logic [VALUE_W-1:0]    value_out,
	output logic                  last_element,
	output logic                  config_error
);

	cfg_t  cfg;
	logic  mid_pop;
	logic  mid_valid;
	item_t mid_item;

	tapa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tapa_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.push          (push),
		.element_bits  (element_bits),
		.first_element (first_element),
		.full          (full),
		.mid_pop       (mid_pop),
		.mid_valid     (mid_valid),
		.mid_item      (mid_item)
	);

	tapa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.mid_valid    (mid_valid),
		.mid_item     (mid_item),
		.mid_pop      (mid_pop),
		.pop          (pop),
		.empty        (empty),
		.dest_index   (dest_index),
		.value_out    (value_out),
		.last_element (last_element),
		.config_error (config_error)
	);

endmodule
